### hw/rtl/tpb_pkg.sv
// Shared types and constants of the turtle plotter bitmap block.
package tpb_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned ROW_IDX_W  = 6;
  localparam int unsigned ROW_BITS_W = 64;

  typedef enum logic [OP_W-1:0] {
    OP_PEN_UP   = 3'd0,
    OP_PEN_DOWN = 3'd1,
    OP_RIGHT    = 3'd2,
    OP_LEFT     = 3'd3,
    OP_MOVE     = 3'd4,
    OP_DUMP     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } heading_e;

endpackage

### hw/rtl/tpb_if.sv
// Handshake channels of the turtle plotter: the command channel and the row channel.
interface tpb_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [tpb_pkg::OP_W-1:0]    operation;
  logic [tpb_pkg::STEP_W-1:0]  step_count;

  modport source (output valid, output operation, output step_count, input ready);
  modport sink   (input valid, input operation, input step_count, output ready);
endinterface

interface tpb_row_if;
  logic                            valid;
  logic                            ready;
  logic [tpb_pkg::ROW_IDX_W-1:0]   row_index;
  logic [tpb_pkg::ROW_BITS_W-1:0]  row_bits;
  logic                            last_row;

  modport source (output valid, output row_index, output row_bits, output last_row,
                  input ready);
  modport sink   (input valid, input row_index, input row_bits, input last_row,
                  output ready);
endinterface

### hw/rtl/turtle_plotter_bitmap.sv
// Turtle plotter: pen, heading and position state, bitmap RAM and step sequencer.
// One command is taken at a time; ready is high only while the sequencer is idle.
// Pen, turn and unused commands complete in the idle state; a move walks its steps one at a time,
// reading and then writing the row for each step with the pen down, and ends early at the grid edge.
// A dump reads each row through the single RAM read port and then loads it, waiting on output stalls.
// Reset clears pen, heading, position and the per-row valid flags; an unwritten row reads as zero.
module turtle_plotter_bitmap #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpb_cmd_if.sink    cmd_i,
  tpb_row_if.source  row_o
);

  localparam int unsigned CW = $clog2(GRID_SIZE);
  localparam logic [CW-1:0] Edge = CW'(GRID_SIZE - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_STEP = 5'b00010,
    S_MARK = 5'b00100,
    S_DRD  = 5'b01000,
    S_DLD  = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic                         pen_q, pen_d;
  logic [1:0]                   head_q, head_d;
  logic [CW-1:0]                pos_x_q, pos_x_d;
  logic [CW-1:0]                pos_y_q, pos_y_d;
  logic [tpb_pkg::STEP_W-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]                row_cnt_q, row_cnt_d;
  logic [GRID_SIZE-1:0]         row_vld_q, row_vld_d;
  logic                         rd_vld_q, rd_vld_d;

  logic                         out_valid_q, out_valid_d;
  logic [tpb_pkg::ROW_IDX_W-1:0]  out_idx_q;
  logic [tpb_pkg::ROW_BITS_W-1:0] out_bits_q;
  logic                         out_last_q;
  logic                         out_load;

  logic                         ram_we, ram_re;
  logic [CW-1:0]                ram_waddr, ram_raddr;
  logic [GRID_SIZE-1:0]         ram_wdata, ram_rdata, row_data;

  logic                         at_edge;
  logic [CW-1:0]                next_x, next_y;

  tpb_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A row that has never been written reads as cleared.
  assign row_data = rd_vld_q ? ram_rdata : '0;

  // Shared step unit: edge check and neighbouring cell along the heading.
  always_comb begin
    at_edge = 1'b0;
    next_x  = pos_x_q;
    next_y  = pos_y_q;
    case (tpb_pkg::heading_e'(head_q))
      tpb_pkg::HEAD_UP: begin
        at_edge = (pos_y_q >= Edge);
        next_y  = pos_y_q + CW'(1);
      end
      tpb_pkg::HEAD_RIGHT: begin
        at_edge = (pos_x_q >= Edge);
        next_x  = pos_x_q + CW'(1);
      end
      tpb_pkg::HEAD_DOWN: begin
        at_edge = (pos_y_q == '0);
        next_y  = pos_y_q - CW'(1);
      end
      default: begin
        at_edge = (pos_x_q == '0);
        next_x  = pos_x_q - CW'(1);
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    pen_d     = pen_q;
    head_d    = head_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    cnt_d     = cnt_q;
    row_cnt_d = row_cnt_q;
    row_vld_d = row_vld_q;
    rd_vld_d  = rd_vld_q;
    ram_we    = 1'b0;
    ram_waddr = pos_y_q;
    ram_wdata = row_data | (GRID_SIZE'(1) << pos_x_q);
    ram_re    = 1'b0;
    ram_raddr = next_y;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          case (cmd_i.operation)
            tpb_pkg::OP_PEN_UP:   pen_d  = 1'b0;
            tpb_pkg::OP_PEN_DOWN: pen_d  = 1'b1;
            tpb_pkg::OP_RIGHT:    head_d = head_q + 2'd1;
            tpb_pkg::OP_LEFT:     head_d = head_q - 2'd1;
            tpb_pkg::OP_MOVE: begin
              cnt_d = cmd_i.step_count;
              if (cmd_i.step_count != '0) begin
                state_d = S_STEP;
              end
            end
            tpb_pkg::OP_DUMP: begin
              row_cnt_d = '0;
              state_d   = S_DRD;
            end
            default: ;
          endcase
        end
      end
      S_STEP: begin
        if (at_edge) begin
          state_d = S_IDLE;
        end else begin
          pos_x_d = next_x;
          pos_y_d = next_y;
          cnt_d   = cnt_q - tpb_pkg::STEP_W'(1);
          if (pen_q) begin
            // Fetch the row being entered; the mark is written next cycle.
            ram_re   = 1'b1;
            ram_raddr = next_y;
            rd_vld_d = row_vld_q[next_y];
            state_d  = S_MARK;
          end else if (cnt_q == tpb_pkg::STEP_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_MARK: begin
        ram_we             = 1'b1;
        row_vld_d[pos_y_q] = 1'b1;
        state_d            = (cnt_q == '0) ? S_IDLE : S_STEP;
      end
      S_DRD: begin
        // Only read once the output register is free by the next cycle.
        if (!out_valid_q || row_o.ready) begin
          ram_re    = 1'b1;
          ram_raddr = row_cnt_q;
          rd_vld_d  = row_vld_q[row_cnt_q];
          state_d   = S_DLD;
        end
      end
      S_DLD: begin
        out_load  = 1'b1;
        row_cnt_d = row_cnt_q + CW'(1);
        state_d   = (row_cnt_q == Edge) ? S_IDLE : S_DRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (row_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pen_q       <= 1'b0;
      head_q      <= 2'd0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      cnt_q       <= '0;
      row_cnt_q   <= '0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pen_q       <= pen_d;
      head_q      <= head_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      cnt_q       <= cnt_d;
      row_cnt_q   <= row_cnt_d;
      row_vld_q   <= row_vld_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= tpb_pkg::ROW_IDX_W'(row_cnt_q);
      out_bits_q <= tpb_pkg::ROW_BITS_W'(row_data);
      out_last_q <= (row_cnt_q == Edge);
    end
  end

  assign cmd_i.ready     = (state_q == S_IDLE);
  assign row_o.valid     = out_valid_q;
  assign row_o.row_index = out_idx_q;
  assign row_o.row_bits  = out_bits_q;
  assign row_o.last_row  = out_last_q;

endmodule

### hw/rtl/tpb_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tpb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
